// ----- sv/bict_pkg.sv -----
package bict_pkg;

  localparam int CoordW   = 8;
  localparam int AddrW    = 2 * CoordW;
  localparam int DimW     = CoordW + 1;
  localparam int StackAw  = 2 * CoordW - 2;
  localparam int StepW    = AddrW + 4;
  localparam int QPtrW    = AddrW + 1;
  localparam int CntW     = StackAw + 1;
  localparam int MaxDim   = 1 << CoordW;

  localparam logic [1:0] CfgWidth  = 2'd0;
  localparam logic [1:0] CfgHeight = 2'd1;

  // One queued item
  typedef struct packed {
    logic kind;
    logic pixel;
  } cmd_t;

  // Neighbor lookup result
  typedef struct packed {
    logic             ok;
    logic [AddrW-1:0] addr;
  } nb_t;

  function automatic logic signed [1:0] step_dx(input logic [2:0] d);
    logic signed [1:0] r;
    unique case (d)
      3'd0, 3'd1, 3'd7: r = 2'sd1;
      3'd2, 3'd6:       r = 2'sd0;
      default:          r = -2'sd1;
    endcase
    return r;
  endfunction

  function automatic logic signed [1:0] step_dy(input logic [2:0] d);
    logic signed [1:0] r;
    unique case (d)
      3'd1, 3'd2, 3'd3: r = 2'sd1;
      3'd0, 3'd4:       r = 2'sd0;
      default:          r = -2'sd1;
    endcase
    return r;
  endfunction

  // Neighbor of pos in direction d, inside the w x h image
  function automatic nb_t neighbor(input logic [AddrW-1:0] pos, input logic [2:0] d,
                                   input logic [DimW-1:0] w, input logic [DimW-1:0] h);
    logic signed [DimW:0] nx;
    logic signed [DimW:0] ny;
    nb_t r;
    nx = $signed({2'b00, pos[CoordW-1:0]}) + (DimW+1)'(step_dx(d));
    ny = $signed({2'b00, pos[AddrW-1:CoordW]}) + (DimW+1)'(step_dy(d));
    r.ok   = !nx[DimW] && !ny[DimW] && (nx[DimW-1:0] < w) && (ny[DimW-1:0] < h);
    r.addr = {ny[CoordW-1:0], nx[CoordW-1:0]};
    return r;
  endfunction

  // Zero reads as one, large values saturate
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) r = DimW'(1);
    else if (v > DimW'(MaxDim)) r = DimW'(MaxDim);
    else r = v;
    return r;
  endfunction

endpackage

// ----- sv/bict_front.sv -----
module bict_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               kind_i,
  input  logic               pixel_value_i,
  output logic               busy_o,
  output logic               cmd_valid_o,
  output bict_pkg::cmd_t     cmd_o,
  input  logic               cmd_pop_i
);
  import bict_pkg::*;

  cmd_t       buf_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign busy_o      = (cnt_q == 2'd2);
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = buf_q[rd_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = cmd_pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Item storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= '{kind: kind_i, pixel: pixel_value_i};
    end
  end

endmodule

// ----- sv/bict_back.sv -----
module bict_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [bict_pkg::DimW-1:0] cfg_data_i,
  input  logic                    cmd_valid_i,
  input  bict_pkg::cmd_t          cmd_i,
  output logic                    cmd_pop_o,
  output logic                    result_valid_o,
  output logic [bict_pkg::CoordW-1:0] point_x_o,
  output logic [bict_pkg::CoordW-1:0] point_y_o,
  output logic                    outline_end_o,
  output logic                    all_end_o,
  output logic                    nothing_left_o
);
  import bict_pkg::*;

  localparam logic [1:0] PH_LOAD = 2'd0;
  localparam logic [1:0] PH_EMIT = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLR    = 4'd1;
  localparam logic [3:0] S_SCAN_P = 4'd2;
  localparam logic [3:0] S_SCAN_C = 4'd3;
  localparam logic [3:0] S_Q_POP  = 4'd4;
  localparam logic [3:0] S_Q_GOT  = 4'd5;
  localparam logic [3:0] S_NB     = 4'd6;
  localparam logic [3:0] S_NB_P   = 4'd7;
  localparam logic [3:0] S_NB_C   = 4'd8;
  localparam logic [3:0] S_PREP   = 4'd9;
  localparam logic [3:0] S_PREP_P = 4'd10;
  localparam logic [3:0] S_PREP_G = 4'd11;
  localparam logic [3:0] S_TM_DIR = 4'd12;
  localparam logic [3:0] S_TM_P   = 4'd13;
  localparam logic [3:0] S_TM_C   = 4'd14;

  localparam int StoreDepth = 1 << AddrW;
  localparam int StackDepth = 1 << StackAw;

  // Memories
  logic             pix_mem [StoreDepth];
  logic             vis_mem [StoreDepth];
  logic [AddrW-1:0] q_mem   [StoreDepth];
  logic [AddrW-1:0] st_mem  [StackDepth];
  logic             pix_rd_q, vis_rd_q;
  logic [AddrW-1:0] q_rd_q, st_rd_q;

  // Control and datapath registers
  logic [3:0]        st_q, st_d;
  logic [1:0]        ph_q, ph_d;
  logic [DimW-1:0]   w_q, w_d, h_q, h_d;
  logic [CoordW-1:0] lx_q, lx_d, ly_q, ly_d;
  logic [CoordW-1:0] sx_q, sx_d, sy_q, sy_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [StepW-1:0]  lim_q, lim_d, step_q, step_d;
  logic [QPtrW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [AddrW-1:0]  addr_q, addr_d, clr_q, clr_d, p_q, p_d;
  logic [AddrW-1:0]  tpos_q, tpos_d, org_q, org_d, pend_q, pend_d, tm_pos_q, tm_pos_d;
  logic [2:0]        hd_q, hd_d, nd_q, nd_d, tm_h_q, tm_h_d, tm_i_q, tm_i_d;
  logic [2:0]        tm_dir_q, tm_dir_d;
  logic              tm_chk_q, tm_chk_d, tm_rd_q, tm_rd_d, prep_rd_q, prep_rd_d;
  logic              ov_q, ov_d, oe_q, oe_d, oa_q, oa_d, on_q, on_d;
  logic [CoordW-1:0] ox_q, ox_d, oy_q, oy_d;

  // Memory write controls
  logic             pix_we, vis_we, vis_wd, q_we, st_we;
  logic [AddrW-1:0] pix_wa, vis_wa, q_wa, q_wd;

  // Combinational helpers
  logic [CoordW-1:0]   ex, ey;
  logic                fr_done, scan_last, tm_fin, tm_move, prep_fin;
  logic [2:0]          tdir;
  nb_t                 nb;
  logic [2*DimW-1:0]   wh;

  assign wh = (2*DimW)'(w_q) * (2*DimW)'(h_q);

  always_comb begin
    st_d = st_q; ph_d = ph_q; w_d = w_q; h_d = h_q;
    lx_d = lx_q; ly_d = ly_q; sx_d = sx_q; sy_d = sy_q;
    cnt_d = cnt_q; lim_d = lim_q; step_d = step_q;
    head_d = head_q; tail_d = tail_q; addr_d = addr_q; clr_d = clr_q; p_d = p_q;
    tpos_d = tpos_q; org_d = org_q; pend_d = pend_q; tm_pos_d = tm_pos_q;
    hd_d = hd_q; nd_d = nd_q; tm_h_d = tm_h_q; tm_i_d = tm_i_q; tm_dir_d = tm_dir_q;
    tm_chk_d = tm_chk_q; tm_rd_d = tm_rd_q; prep_rd_d = prep_rd_q;
    ov_d = 1'b0; oe_d = oe_q; oa_d = oa_q; on_d = on_q; ox_d = ox_q; oy_d = oy_q;
    pix_we = 1'b0; pix_wa = '0;
    vis_we = 1'b0; vis_wa = addr_q; vis_wd = 1'b0;
    q_we = 1'b0; q_wa = tail_q[AddrW-1:0]; q_wd = addr_q;
    st_we = 1'b0;
    cmd_pop_o = 1'b0;
    tm_fin = 1'b0; tm_move = 1'b0; prep_fin = 1'b0;
    ex = '0; ey = '0; fr_done = 1'b0;
    scan_last = ({1'b0, sx_q} == w_q - DimW'(1)) && ({1'b0, sy_q} == h_q - DimW'(1));
    tdir = tm_h_q + tm_i_q + 3'd6;
    nb = neighbor(tm_pos_q, tdir, w_q, h_q);

    unique case (st_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (!cmd_i.kind) begin
            // Pixel load
            ex = (ph_q != PH_LOAD) ? '0 : lx_q;
            ey = (ph_q != PH_LOAD) ? '0 : ly_q;
            if (ph_q != PH_LOAD) cnt_d = '0;
            ph_d = PH_LOAD;
            pix_we = 1'b1;
            pix_wa = {ey, ex};
            fr_done = ({1'b0, ex} == w_q - DimW'(1)) && ({1'b0, ey} == h_q - DimW'(1));
            if ({1'b0, ex} == w_q - DimW'(1)) begin
              lx_d = '0;
              ly_d = ey + CoordW'(1);
            end else begin
              lx_d = ex + CoordW'(1);
              ly_d = ey;
            end
            if (fr_done) begin
              clr_d = '0;
              st_d  = S_CLR;
            end
          end else if (ph_q != PH_EMIT) begin
            ov_d = 1'b1; on_d = 1'b1; oe_d = 1'b0; oa_d = 1'b0; ox_d = '0; oy_d = '0;
          end else begin
            // Point read: step the tracer
            tm_pos_d = tpos_q; tm_h_d = hd_q; tm_i_d = '0;
            tm_chk_d = 1'b1; tm_rd_d = 1'b1;
            st_d = S_TM_DIR;
          end
        end
      end
      S_CLR: begin
        vis_we = 1'b1; vis_wa = clr_q; vis_wd = 1'b0;
        clr_d = clr_q + AddrW'(1);
        if (clr_q == '1) begin
          sx_d = '0; sy_d = '0; addr_d = '0; cnt_d = '0;
          lim_d = StepW'({wh[AddrW:0], 3'b000});
          st_d = S_SCAN_P;
        end
      end
      S_SCAN_P: st_d = S_SCAN_C;
      S_SCAN_C: begin
        if (pix_rd_q && !vis_rd_q) begin
          // New component: record its start and seed the fill
          if (cnt_q < CntW'(StackDepth)) begin
            st_we = 1'b1;
            cnt_d = cnt_q + CntW'(1);
          end
          vis_we = 1'b1; vis_wd = 1'b1;
          q_we = 1'b1; q_wa = '0;
          head_d = '0; tail_d = QPtrW'(1);
          st_d = S_Q_POP;
        end else if (scan_last) begin
          prep_rd_d = 1'b0;
          st_d = S_PREP;
        end else begin
          if ({1'b0, sx_q} == w_q - DimW'(1)) begin
            sx_d = '0; sy_d = sy_q + CoordW'(1);
          end else begin
            sx_d = sx_q + CoordW'(1);
          end
          addr_d = {sy_d, sx_d};
          st_d = S_SCAN_P;
        end
      end
      S_Q_POP: begin
        if (head_q == tail_q) begin
          if (scan_last) begin
            prep_rd_d = 1'b0;
            st_d = S_PREP;
          end else begin
            if ({1'b0, sx_q} == w_q - DimW'(1)) begin
              sx_d = '0; sy_d = sy_q + CoordW'(1);
            end else begin
              sx_d = sx_q + CoordW'(1);
            end
            addr_d = {sy_d, sx_d};
            st_d = S_SCAN_P;
          end
        end else begin
          st_d = S_Q_GOT;
        end
      end
      S_Q_GOT: begin
        p_d = q_rd_q;
        head_d = head_q + QPtrW'(1);
        nd_d = '0;
        st_d = S_NB;
      end
      S_NB: begin
        nb = neighbor(p_q, nd_q, w_q, h_q);
        if (nb.ok) begin
          addr_d = nb.addr;
          st_d = S_NB_P;
        end else begin
          nd_d = nd_q + 3'd1;
          st_d = (nd_q == 3'd7) ? S_Q_POP : S_NB;
        end
      end
      S_NB_P: st_d = S_NB_C;
      S_NB_C: begin
        if (pix_rd_q && !vis_rd_q) begin
          vis_we = 1'b1; vis_wd = 1'b1;
          q_we = 1'b1;
          tail_d = tail_q + QPtrW'(1);
        end
        nd_d = nd_q + 3'd1;
        st_d = (nd_q == 3'd7) ? S_Q_POP : S_NB;
      end
      S_PREP: begin
        if (cnt_q == '0) begin
          ph_d = PH_DONE;
          prep_fin = 1'b1;
        end else begin
          cnt_d = cnt_q - CntW'(1);
          st_d = S_PREP_P;
        end
      end
      S_PREP_P: st_d = S_PREP_G;
      S_PREP_G: begin
        tm_pos_d = st_rd_q; tm_h_d = '0; tm_i_d = '0;
        tm_chk_d = 1'b0; tm_rd_d = 1'b0;
        st_d = S_TM_DIR;
      end
      S_TM_DIR: begin
        if (tm_chk_q && tm_pos_q == org_q && tdir == 3'd0) begin
          tm_fin = 1'b1;
        end else if (nb.ok) begin
          addr_d = nb.addr; tm_dir_d = tdir;
          st_d = S_TM_P;
        end else if (tm_i_q == 3'd6) begin
          tm_fin = 1'b1;
        end else begin
          tm_i_d = tm_i_q + 3'd1;
        end
      end
      S_TM_P: st_d = S_TM_C;
      S_TM_C: begin
        if (pix_rd_q) begin
          tm_fin = 1'b1; tm_move = 1'b1;
        end else if (tm_i_q == 3'd6) begin
          tm_fin = 1'b1;
        end else begin
          tm_i_d = tm_i_q + 3'd1;
          st_d = S_TM_DIR;
        end
      end
      default: st_d = S_IDLE;
    endcase

    // Outcome of one trace move
    if (tm_fin) begin
      if (!tm_rd_q) begin
        if (tm_move) begin
          pend_d = tm_pos_q; org_d = tm_pos_q; tpos_d = addr_q; hd_d = tm_dir_q;
          step_d = '0; ph_d = PH_EMIT;
          prep_fin = 1'b1;
        end else begin
          st_d = S_PREP;
        end
      end else begin
        ox_d = pend_q[CoordW-1:0];
        oy_d = pend_q[AddrW-1:CoordW];
        on_d = 1'b0;
        step_d = step_q + StepW'(1);
        if (tm_move && (step_q + StepW'(1) <= lim_q)) begin
          pend_d = tpos_q; tpos_d = addr_q; hd_d = tm_dir_q;
          ov_d = 1'b1; oe_d = 1'b0; oa_d = 1'b0;
          st_d = S_IDLE;
        end else begin
          prep_rd_d = 1'b1;
          st_d = S_PREP;
        end
      end
    end

    // End of outline preparation
    if (prep_fin) begin
      st_d = S_IDLE;
      if (prep_rd_q) begin
        ov_d = 1'b1; oe_d = 1'b1; oa_d = (ph_d != PH_EMIT);
      end
    end

    // Register writes restart the frame
    if (cfg_we_i && (cfg_idx_i == CfgWidth || cfg_idx_i == CfgHeight)) begin
      if (cfg_idx_i == CfgWidth) w_d = clamp_dim(cfg_data_i);
      else h_d = clamp_dim(cfg_data_i);
      ph_d = PH_LOAD; cnt_d = '0; lx_d = '0; ly_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ph_q <= PH_LOAD;
      w_q <= DimW'(MaxDim); h_q <= DimW'(MaxDim);
      lx_q <= '0; ly_q <= '0; cnt_q <= '0; step_q <= '0;
      tpos_q <= '0; org_q <= '0; pend_q <= '0; hd_q <= '0;
      tm_rd_q <= 1'b0; prep_rd_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; ph_q <= ph_d; w_q <= w_d; h_q <= h_d;
      lx_q <= lx_d; ly_q <= ly_d; cnt_q <= cnt_d; step_q <= step_d;
      tpos_q <= tpos_d; org_q <= org_d; pend_q <= pend_d; hd_q <= hd_d;
      tm_rd_q <= tm_rd_d; prep_rd_q <= prep_rd_d; ov_q <= ov_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    sx_q <= sx_d; sy_q <= sy_d; lim_q <= lim_d;
    head_q <= head_d; tail_q <= tail_d; addr_q <= addr_d; clr_q <= clr_d; p_q <= p_d;
    tm_pos_q <= tm_pos_d; nd_q <= nd_d; tm_h_q <= tm_h_d; tm_i_q <= tm_i_d;
    tm_dir_q <= tm_dir_d; tm_chk_q <= tm_chk_d;
    oe_q <= oe_d; oa_q <= oa_d; on_q <= on_d; ox_q <= ox_d; oy_q <= oy_d;
  end

  // Pixel and visited stores
  always_ff @(posedge clk_i) begin
    if (pix_we) pix_mem[pix_wa] <= cmd_i.pixel;
    pix_rd_q <= pix_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_rd_q <= vis_mem[addr_q];
  end

  // Fill queue and start stack
  always_ff @(posedge clk_i) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    q_rd_q <= q_mem[head_q[AddrW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (st_we) st_mem[cnt_q[StackAw-1:0]] <= addr_q;
    st_rd_q <= st_mem[cnt_q[StackAw-1:0]];
  end

  assign result_valid_o = ov_q;
  assign point_x_o      = ox_q;
  assign point_y_o      = oy_q;
  assign outline_end_o  = oe_q;
  assign all_end_o      = oa_q;
  assign nothing_left_o = on_q;

endmodule

// ----- sv/binary_image_contour_tracer_top.sv -----
// Binary image contour tracer.
// Items enter on start_i while busy_o is low: kind_i 0 loads the next pixel
// (pixel_value_i) in raster order, kind_i 1 reads the next outline point.
// A two-item queue sits in front of the engine, so busy_o rises only when
// both slots are taken.
// A load gives no result. A read gives one result, marked by result_valid_o
// for a single cycle; the receiver cannot stall it.
// The last pixel of a frame starts labeling: a clear of all visited marks,
// then a raster scan and a flood fill that probes the eight neighbors of
// each filled pixel inside the image, then preparation of the first outline.
// A read tries up to seven directions per trace step, reading the pixel
// store only for those inside the image; the read that closes an outline
// also prepares the next one, popping start points until one can move.
// Register writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once and
// restart the frame; write them only while no item is pending.
// Reset sets both dimensions to 256 and waits for the first pixel.
module binary_image_contour_tracer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        kind_i,
  input  logic                        pixel_value_i,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [bict_pkg::DimW-1:0]   cfg_data_i,
  output logic                        result_valid_o,
  output logic [bict_pkg::CoordW-1:0] point_x_o,
  output logic [bict_pkg::CoordW-1:0] point_y_o,
  output logic                        outline_end_o,
  output logic                        all_end_o,
  output logic                        nothing_left_o
);
  import bict_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  bict_front u_front (
    .clk_i, .rst_ni, .start_i, .kind_i, .pixel_value_i, .busy_o,
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  bict_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .result_valid_o, .point_x_o, .point_y_o, .outline_end_o, .all_end_o, .nothing_left_o
  );

endmodule

// ----- sim/testbench.sv -----
module testbench;
  import bict_pkg::*;

  typedef enum logic [1:0] {OP_LOAD, OP_READ, OP_CFG, OP_DRAIN} op_e;
  typedef enum logic [1:0] {PH_LOAD, PH_EMIT, PH_DONE} phase_e;
  typedef enum logic [1:0] {MV_NONE, MV_STEP, MV_CLOSE} move_e;

  typedef struct {
    op_e              op;
    logic             pv;
    logic [1:0]       idx;
    logic [DimW-1:0]  data;
  } plan_t;

  typedef struct {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              oe;
    logic              ae;
    logic              nl;
  } point_t;

  localparam int RowPitch = MaxDim;
  localparam int WatchdogLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i, kind_i, pixel_value_i, cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [DimW-1:0] cfg_data_i;
  logic busy_o, result_valid_o, outline_end_o, all_end_o, nothing_left_o;
  logic [CoordW-1:0] point_x_o, point_y_o;

  binary_image_contour_tracer_top dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mirror of the tracer state
  bit          pix_mem [RowPitch*MaxDim];
  bit          seen_mem [RowPitch*MaxDim];
  int unsigned start_pts [$];
  int unsigned img_w = MaxDim, img_h = MaxDim;
  int unsigned load_pos, trace_pos, trace_org, pend_pt, step_cnt;
  logic [2:0]  trace_hd;
  phase_e      ph = PH_LOAD;

  point_t      expected_points [$];
  plan_t       plan [$];
  int          errors, frames_done, points_seen, outlines_seen, empties_seen;
  int          items_sent;

  const int dir_x [8] = '{1, 1, 0, -1, -1, -1, 0, 1};
  const int dir_y [8] = '{0, 1, 1, 1, 0, -1, -1, -1};

  function automatic int unsigned clamp_size(logic [DimW-1:0] v);
    if (v == 0) return 1;
    if (v > MaxDim) return MaxDim;
    return v;
  endfunction

  function automatic bit is_shape(int x, int y);
    if (x < 0 || y < 0 || x >= int'(img_w) || y >= int'(img_h)) return 1'b0;
    return pix_mem[y * RowPitch + x];
  endfunction

  // Scan headings -2..+4 around hd from pos
  function automatic move_e probe(int unsigned pos, inout logic [2:0] hd, input bit chk,
                                  output int unsigned nxt);
    int x, y, i, t, nx, ny;
    logic [2:0] d;
    x = pos % RowPitch;
    y = pos / RowPitch;
    nxt = 0;
    for (i = -2; i <= 4; i++) begin
      t = int'(hd) + i;
      d = 3'((t + 8) & 7);
      if (chk && pos == trace_org && (t == 0 || t == 8)) return MV_CLOSE;
      nx = x + dir_x[d];
      ny = y + dir_y[d];
      if (is_shape(nx, ny)) begin
        hd = d;
        nxt = ny * RowPitch + nx;
        return MV_STEP;
      end
    end
    return MV_NONE;
  endfunction

  function automatic void next_outline();
    int unsigned s, n;
    logic [2:0] h;
    while (start_pts.size() > 0) begin
      s = start_pts[$];
      start_pts.delete(start_pts.size() - 1);
      h = 3'd0;
      if (probe(s, h, 1'b0, n) == MV_STEP) begin
        pend_pt = s;
        trace_org = s;
        trace_pos = n;
        trace_hd = h;
        step_cnt = 0;
        ph = PH_EMIT;
        return;
      end
    end
    ph = PH_DONE;
  endfunction

  // Flood fill; start point of each component is its first raster pixel
  function automatic void find_components();
    int unsigned fq [$];
    int unsigned idx, p, q;
    int px, py, nx, ny, d;
    for (int y = 0; y < int'(img_h); y++)
      for (int x = 0; x < int'(img_w); x++) seen_mem[y * RowPitch + x] = 1'b0;
    start_pts.delete();
    for (int y = 0; y < int'(img_h); y++) begin
      for (int x = 0; x < int'(img_w); x++) begin
        idx = y * RowPitch + x;
        if (!pix_mem[idx] || seen_mem[idx]) continue;
        start_pts.insert(start_pts.size(), idx);
        seen_mem[idx] = 1'b1;
        fq.insert(fq.size(), idx);
        while (fq.size() > 0) begin
          p = fq.pop_front();
          px = p % RowPitch;
          py = p / RowPitch;
          for (d = 0; d < 8; d++) begin
            nx = px + dir_x[d];
            ny = py + dir_y[d];
            if (!is_shape(nx, ny)) continue;
            q = ny * RowPitch + nx;
            if (seen_mem[q]) continue;
            seen_mem[q] = 1'b1;
            fq.insert(fq.size(), q);
          end
        end
      end
    end
  endfunction

  function automatic void restart_frame();
    load_pos = 0;
    start_pts.delete();
    ph = PH_LOAD;
  endfunction

  function automatic void apply_register(logic [1:0] idx, logic [DimW-1:0] v);
    if (idx == CfgWidth) img_w = clamp_size(v);
    else img_h = clamp_size(v);
    restart_frame();
  endfunction

  function automatic void predict_item(logic knd, logic pv);
    point_t r;
    int unsigned n;
    logic [2:0] h;
    move_e act;
    if (!knd) begin
      if (ph != PH_LOAD) restart_frame();
      if (load_pos / img_w < img_h)
        pix_mem[(load_pos / img_w) * RowPitch + load_pos % img_w] = pv;
      load_pos++;
      if (load_pos >= img_w * img_h) begin
        find_components();
        next_outline();
        frames_done++;
      end
      return;
    end
    r = '{default: '0};
    if (ph != PH_EMIT) begin
      r.nl = 1'b1;
    end else begin
      r.x = CoordW'(pend_pt % RowPitch);
      r.y = CoordW'(pend_pt / RowPitch);
      h = trace_hd;
      act = probe(trace_pos, h, 1'b1, n);
      step_cnt++;
      if (act == MV_STEP && step_cnt <= 8 * img_w * img_h) begin
        pend_pt = trace_pos;
        trace_pos = n;
        trace_hd = h;
      end else begin
        r.oe = 1'b1;
        next_outline();
        r.ae = (ph != PH_EMIT);
      end
    end
    expected_points.insert(expected_points.size(), r);
  endfunction

  task automatic report(string what, int got, int want);
    $display("MISMATCH @%0t %s: got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Driver
  int   gap, settle;
  bit   burst;
  logic st_n, we_n;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      kind_i <= 1'b0;
      pixel_value_i <= 1'b0;
      cfg_we_i <= 1'b0;
      cfg_idx_i <= CfgWidth;
      cfg_data_i <= '0;
    end else begin
      st_n = start_i;
      we_n = 1'b0;
      if (start_i && !busy_o) begin
        predict_item(kind_i, pixel_value_i);
        items_sent++;
        st_n = 1'b0;
      end
      settle = (expected_points.size() == 0 && !st_n) ? settle + 1 : 0;
      if (!(start_i && busy_o) && plan.size() > 0) begin
        if (gap > 0) begin
          gap--;
        end else begin
          case (plan[0].op)
            OP_LOAD, OP_READ: begin
              st_n = 1'b1;
              kind_i <= (plan[0].op == OP_READ);
              pixel_value_i <= plan[0].pv;
              void'(plan.pop_front());
              if ($urandom_range(0, 63) == 0) burst = !burst;
              gap = burst ? 0 : $urandom_range(0, 19);
            end
            OP_CFG: if (settle >= 16) begin
              we_n = 1'b1;
              cfg_idx_i <= plan[0].idx;
              cfg_data_i <= plan[0].data;
              apply_register(plan[0].idx, plan[0].data);
              void'(plan.pop_front());
            end
            default: if (settle >= 16) void'(plan.pop_front());
          endcase
        end
      end
      start_i <= st_n;
      cfg_we_i <= we_n;
    end
  end

  // Result checker
  point_t want;

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_points.size() == 0) begin
        $display("MISMATCH @%0t unexpected point", $time);
        errors++;
      end else begin
        want = expected_points.pop_front();
        if (point_x_o !== want.x) report("point_x", point_x_o, want.x);
        if (point_y_o !== want.y) report("point_y", point_y_o, want.y);
        if (outline_end_o !== want.oe) report("outline_end", outline_end_o, want.oe);
        if (all_end_o !== want.ae) report("all_end", all_end_o, want.ae);
        if (nothing_left_o !== want.nl) report("nothing_left", nothing_left_o, want.nl);
        if (want.nl) empties_seen++;
        else points_seen++;
        if (want.oe) outlines_seen++;
      end
    end
  end

  // Watchdog on progress
  int quiet;

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || cfg_we_i) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchdogLimit) begin
      $display("timeout after %0d idle cycles", quiet);
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic add_op(op_e op, logic pv = 1'b0, logic [1:0] idx = CfgWidth,
                        logic [DimW-1:0] d = '0);
    plan_t p;
    p.op = op;
    p.pv = pv;
    p.idx = idx;
    p.data = d;
    plan.insert(plan.size(), p);
  endtask

  task automatic add_reads(int n);
    for (int i = 0; i < n; i++) add_op(OP_READ);
  endtask

  task automatic add_pixels(int n, int density);
    for (int i = 0; i < n; i++) add_op(OP_LOAD, $urandom_range(0, 99) < density);
  endtask

  // Idle point then dimensions; both registers always written
  task automatic set_size(logic [DimW-1:0] w, logic [DimW-1:0] h);
    add_op(OP_DRAIN);
    add_op(OP_CFG, 1'b0, CfgWidth, w);
    add_op(OP_CFG, 1'b0, CfgHeight, h);
  endtask

  int planned;
  int w, h, dens;
  const bit demo_img [20] = '{1,0,0,1,1, 0,0,0,1,1, 1,1,0,0,0, 0,0,0,0,1};

  initial begin
    // Read before any frame, then a 5x4 frame with single pixels, a block and a bar
    add_reads(1);
    set_size(9'd5, 9'd4);
    foreach (demo_img[i]) add_op(OP_LOAD, demo_img[i]);
    add_reads(14);
    // Zero reads as one: a lone pixel gives no outline
    set_size(9'd0, 9'd0);
    add_op(OP_LOAD, 1'b1);
    add_reads(2);
    // Saturated width, single row
    set_size(9'd511, 9'd1);
    add_pixels(256, 60);
    add_reads(40);
    // Widest legal, then saturated height in one column
    set_size(9'd256, 9'd300);
    add_op(OP_DRAIN);
    add_op(OP_CFG, 1'b0, CfgWidth, 9'd1);
    add_pixels(256, 70);
    add_reads(30);
    planned = plan.size();
    // Random frames of small size
    while (planned < 1500) begin
      w = $urandom_range(0, 9) == 0 ? 1 : $urandom_range(2, 16);
      h = $urandom_range(0, 9) == 0 ? 1 : $urandom_range(2, 16);
      dens = $urandom_range(10, 90);
      set_size(DimW'(w), DimW'(h));
      if ($urandom_range(0, 4) == 0) begin
        // Broken frame: partial or full load, early read, then restart via a width write
        add_pixels($urandom_range(1, w * h), dens);
        add_reads(1);
        add_op(OP_DRAIN);
        add_op(OP_CFG, 1'b0, CfgWidth, DimW'(w));
      end
      add_pixels(w * h, dens);
      add_reads($urandom_range(1, w * h + 4));
      if ($urandom_range(0, 5) == 0) begin
        // Load after a complete frame drops the rest of the readout
        add_pixels(w * h, dens);
        add_reads($urandom_range(1, w * h + 4));
      end
      planned = plan.size();
    end
    add_reads(1);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (plan.size() > 0 || start_i || expected_points.size() > 0);
    repeat (200) @(posedge clk_i);
    $display("%0d items in %0d frames, %0d points in %0d outlines, %0d empty reads",
             items_sent, frames_done, points_seen, outlines_seen, empties_seen);
    if (errors == 0 && expected_points.size() == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule

// ----- binary_image_contour_tracer_top.f -----
sv/bict_pkg.sv
sv/bict_front.sv
sv/bict_back.sv
sv/binary_image_contour_tracer_top.sv
sim/testbench.sv
